[hdl/strided_slice_address_generator_top_macros.svh]
// Assertion helpers for the strided slice address generator.
`ifndef STRIDED_SLICE_ADDRESS_GENERATOR_TOP_MACROS_SVH
`define STRIDED_SLICE_ADDRESS_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define SSAG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssag: same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define SSAG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssag: next-cycle check failed");

`endif

[hdl/ssag_pkg.sv]
package ssag_pkg;

    localparam int AXIS_BITS = 16;
    localparam int SLOT_BITS = 16;
    localparam int NUM_AXES  = 4;
    localparam int AX_W      = $clog2(NUM_AXES);
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int MASK_W    = NUM_AXES;
    localparam int OFF_W     = 64;
    // Working width for start/stop arithmetic, stored stop width, next-index width.
    localparam int SW        = AXIS_BITS + 3;
    localparam int PW        = AXIS_BITS + 1;
    localparam int NW        = AXIS_BITS + 2;
    // Offset accumulator operand and product widths.
    localparam int MAC_W     = 3 * AXIS_BITS;
    localparam int PROD_W    = 4 * AXIS_BITS;

    localparam logic signed [SW-1:0] ZERO_S  = SW'(0);
    localparam logic signed [SW-1:0] ONE_S   = SW'(1);
    // Lies outside every reachable index range, so it clamps like the full-range value.
    localparam logic signed [SW-1:0] BIG_POS = SW'(2 ** (AXIS_BITS + 1));
    localparam logic signed [SW-1:0] BIG_NEG = -BIG_POS;

    localparam logic [AX_W-1:0] FIRST_MAC_AXIS = AX_W'(1);
    localparam logic [AX_W-1:0] LAST_AXIS      = AX_W'(NUM_AXES - 1);

    localparam logic [CFG_W-1:0]  RST_AXIS_SIZES    = 64'h0001_0001_0001_0001;
    localparam logic [CFG_W-1:0]  RST_BEGIN_INDICES = 64'h0000_0000_0000_0000;
    localparam logic [CFG_W-1:0]  RST_END_INDICES   = 64'h0001_0001_0001_0001;
    localparam logic [CFG_W-1:0]  RST_AXIS_STRIDES  = 64'h0001_0001_0001_0001;
    localparam logic [MASK_W-1:0] RST_MASK          = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AXIS_SIZES    = 3'd0,
        CFG_BEGIN_INDICES = 3'd1,
        CFG_END_INDICES   = 3'd2,
        CFG_AXIS_STRIDES  = 3'd3,
        CFG_BEGIN_MASK    = 3'd4,
        CFG_END_MASK      = 3'd5,
        CFG_SHRINK_MASK   = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STOP,
        S_OFFSET
    } t_state;

    typedef struct packed {
        logic            accept;
        logic            restart;
        logic            calc_stop;
        logic            mac_en;
        logic [AX_W-1:0] mac_axis;
    } t_dp_cmd;

    typedef struct packed {
        logic active;
        logic out_free;
    } t_dp_stat;

    typedef struct packed {
        logic [OFF_W-1:0] read_offset;
        logic             valid_res;
        logic             last;
        logic             stride_error;
    } t_result;

    function automatic logic [AXIS_BITS-1:0] slot_u(input logic [CFG_W-1:0] word,
                                                    input int ax);
        return word[ax*SLOT_BITS +: AXIS_BITS];
    endfunction

    function automatic logic signed [SW-1:0] sext_ax(input logic [AXIS_BITS-1:0] raw);
        return $signed({{(SW-AXIS_BITS){raw[AXIS_BITS-1]}}, raw});
    endfunction

    function automatic logic signed [SW-1:0] zext_ax(input logic [AXIS_BITS-1:0] raw);
        return $signed({{(SW-AXIS_BITS){1'b0}}, raw});
    endfunction

endpackage

[hdl/ssag_if.sv]
interface ssag_item_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface ssag_res_if import ssag_pkg::*; ;
    logic             valid;
    logic             ready;
    logic [OFF_W-1:0] read_offset;
    logic             valid_res;
    logic             last;
    logic             stride_error;

    modport source (output valid, output read_offset, output valid_res, output last,
                    output stride_error, input ready);
    modport sink   (input valid, input read_offset, input valid_res, input last,
                    input stride_error, output ready);
endinterface

interface ssag_cfg_if import ssag_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/ssag_ctrl.sv]
module ssag_ctrl import ssag_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_restart,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state          r_state, n_state;
    logic [AX_W-1:0] r_axis, n_axis;
    logic            w_accept;

    assign w_accept = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_restart) begin
                        n_state = S_STOP;
                    end else if (i_stat.active) begin
                        n_state = S_OFFSET;
                        n_axis  = FIRST_MAC_AXIS;
                    end
                end
            end
            S_STOP: begin
                n_state = S_OFFSET;
                n_axis  = FIRST_MAC_AXIS;
            end
            S_OFFSET: begin
                if (r_axis == LAST_AXIS) begin
                    n_state = S_IDLE;
                end else begin
                    n_axis = r_axis + AX_W'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = (r_state == S_IDLE) && i_stat.out_free;
        o_cmd.accept    = w_accept;
        o_cmd.restart   = i_restart;
        o_cmd.calc_stop = (r_state == S_STOP);
        o_cmd.mac_en    = (r_state == S_OFFSET);
        o_cmd.mac_axis  = r_axis;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= FIRST_MAC_AXIS;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

endmodule

[hdl/ssag_dp.sv]
module ssag_dp import ssag_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_stat   o_stat,
    ssag_cfg_if.sink   i_cfg,
    ssag_res_if.source o_res
);

    // Configuration registers
    logic [CFG_W-1:0]  r_sizes, r_begins, r_ends, r_strides;
    logic [MASK_W-1:0] r_bmask, r_emask, r_smask;

    // Copies taken when a restart word is accepted
    logic [AXIS_BITS-1:0] r_sz     [NUM_AXES];
    logic [AXIS_BITS-1:0] r_stride [NUM_AXES];
    logic [AXIS_BITS-1:0] r_end    [NUM_AXES];
    logic [MASK_W-1:0]    r_emask_c, r_smask_c;

    // Traversal state
    logic [AXIS_BITS-1:0]   r_start [NUM_AXES];
    logic signed [PW-1:0]   r_stop  [NUM_AXES];
    logic [AXIS_BITS-1:0]   r_cur   [NUM_AXES];
    logic [OFF_W-1:0]       r_acc;
    logic                   r_active;
    logic                   r_err;
    logic                   r_out_valid;
    t_result                r_out;

    logic [AXIS_BITS-1:0]   w_start     [NUM_AXES];
    logic [NUM_AXES-1:0]    w_zero_stride;
    logic signed [PW-1:0]   w_stop      [NUM_AXES];
    logic [NUM_AXES-1:0]    w_empty;
    logic signed [NW-1:0]   w_next      [NUM_AXES];
    logic [NUM_AXES-1:0]    w_done;
    logic [AXIS_BITS-1:0]   w_cur_next  [NUM_AXES];
    logic                   w_step_last;
    logic                   w_new_err;
    logic [MAC_W-1:0]       w_mac_a;
    logic [PROD_W-1:0]      w_prod;
    logic [OFF_W-1:0]       w_mac_sum;
    logic                   w_step;

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        // Start index straight from the configuration registers.
        always_comb begin
            logic signed [SW-1:0] sz;
            logic signed [SW-1:0] s;
            logic signed [SW-1:0] v;
            sz = zext_ax(slot_u(r_sizes, g));
            s  = sext_ax(slot_u(r_strides, g));
            if (r_bmask[g]) begin
                v = (s > ZERO_S) ? BIG_NEG : BIG_POS;
            end else begin
                v = sext_ax(slot_u(r_begins, g));
            end
            if (v < ZERO_S) begin
                v = v + sz;
            end
            if ((sz - ONE_S) < v) begin
                v = sz - ONE_S;
            end else if (v < ZERO_S) begin
                v = ZERO_S;
            end
            w_start[g]       = v[AXIS_BITS-1:0];
            w_zero_stride[g] = (slot_u(r_strides, g) == '0);
        end

        // Stop index from the copies taken at restart; end mask overrides shrink.
        always_comb begin
            logic signed [SW-1:0] sz;
            logic signed [SW-1:0] s;
            logic signed [SW-1:0] st;
            logic signed [SW-1:0] e;
            logic                 fin;
            sz = zext_ax(r_sz[g]);
            s  = sext_ax(r_stride[g]);
            st = zext_ax(r_start[g]);
            e  = sext_ax(r_end[g]);
            if (r_smask_c[g]) begin
                e = st + ONE_S;
            end
            if (r_emask_c[g]) begin
                e = (s > ZERO_S) ? BIG_POS : BIG_NEG;
            end
            if (e < ZERO_S) begin
                e = e + sz;
            end
            if (s > ZERO_S) begin
                if (sz < e) begin
                    e = sz;
                end else if (e < ZERO_S) begin
                    e = ZERO_S;
                end
                fin = (st >= e);
            end else begin
                if ((sz - ONE_S) < e) begin
                    e = sz - ONE_S;
                end else if (e < -ONE_S) begin
                    e = -ONE_S;
                end
                fin = (st <= e);
            end
            w_stop[g]  = e[PW-1:0];
            w_empty[g] = (r_sz[g] == '0) || fin;
        end

        // Candidate next index of this axis and its end test.
        always_comb begin
            logic signed [NW-1:0] s;
            logic signed [NW-1:0] sp;
            s  = NW'(sext_ax(r_stride[g]));
            sp = NW'(r_stop[g]);
            w_next[g] = $signed({2'b00, r_cur[g]}) + s;
            w_done[g] = (s > NW'(0)) ? (w_next[g] >= sp) : (w_next[g] <= sp);
        end
    end

    // Innermost axis advances first; a finished axis returns to its start and carries.
    always_comb begin
        logic carry;
        carry = 1'b1;
        for (int ax = NUM_AXES - 1; ax >= 0; ax--) begin
            w_cur_next[ax] = r_cur[ax];
            if (carry) begin
                if (!w_done[ax]) begin
                    w_cur_next[ax] = w_next[ax][AXIS_BITS-1:0];
                    carry          = 1'b0;
                end else begin
                    w_cur_next[ax] = r_start[ax];
                end
            end
        end
        w_step_last = carry;
    end

    assign w_new_err = |w_zero_stride;
    assign w_step    = i_cmd.accept && !i_cmd.restart && r_active;

    // Offset by nested multiply-add over the axes, one axis per cycle.
    assign w_mac_a   = (i_cmd.mac_axis == FIRST_MAC_AXIS)
                       ? {{(MAC_W-AXIS_BITS){1'b0}}, r_cur[0]} : r_acc[MAC_W-1:0];
    assign w_prod    = w_mac_a * r_sz[i_cmd.mac_axis];
    assign w_mac_sum = OFF_W'(w_prod) + OFF_W'(r_cur[i_cmd.mac_axis]);

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sizes   <= RST_AXIS_SIZES;
            r_begins  <= RST_BEGIN_INDICES;
            r_ends    <= RST_END_INDICES;
            r_strides <= RST_AXIS_STRIDES;
            r_bmask   <= RST_MASK;
            r_emask   <= RST_MASK;
            r_smask   <= RST_MASK;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_AXIS_SIZES:    r_sizes   <= i_cfg.data;
                CFG_BEGIN_INDICES: r_begins  <= i_cfg.data;
                CFG_END_INDICES:   r_ends    <= i_cfg.data;
                CFG_AXIS_STRIDES:  r_strides <= i_cfg.data;
                CFG_BEGIN_MASK:    r_bmask   <= i_cfg.data[MASK_W-1:0];
                CFG_END_MASK:      r_emask   <= i_cfg.data[MASK_W-1:0];
                CFG_SHRINK_MASK:   r_smask   <= i_cfg.data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_cmd.restart) begin
            for (int ax = 0; ax < NUM_AXES; ax++) begin
                r_sz[ax]     <= slot_u(r_sizes, ax);
                r_stride[ax] <= slot_u(r_strides, ax);
                r_end[ax]    <= slot_u(r_ends, ax);
                r_start[ax]  <= w_start[ax];
                r_cur[ax]    <= w_start[ax];
            end
            r_emask_c <= r_emask;
            r_smask_c <= r_smask;
        end else if (w_step) begin
            for (int ax = 0; ax < NUM_AXES; ax++) begin
                r_cur[ax] <= w_cur_next[ax];
            end
        end
        if (i_cmd.calc_stop) begin
            for (int ax = 0; ax < NUM_AXES; ax++) begin
                r_stop[ax] <= w_stop[ax];
            end
        end
        if (i_cmd.mac_en) begin
            r_acc <= w_mac_sum;
        end
        if (i_cmd.accept) begin
            r_out.read_offset  <= w_step ? r_acc : '0;
            r_out.valid_res    <= w_step;
            r_out.last         <= w_step && w_step_last;
            r_out.stride_error <= i_cmd.restart ? w_new_err : r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept && i_cmd.restart) begin
                r_err    <= w_new_err;
                r_active <= 1'b0;
            end else if (w_step && w_step_last) begin
                r_active <= 1'b0;
            end else if (i_cmd.calc_stop) begin
                r_active <= !r_err && !(|w_empty);
            end
            if (i_cmd.accept) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.active   = r_active;
    assign o_stat.out_free = !r_out_valid || o_res.ready;

    assign o_res.valid        = r_out_valid;
    assign o_res.read_offset  = r_out.read_offset;
    assign o_res.valid_res    = r_out.valid_res;
    assign o_res.last         = r_out.last;
    assign o_res.stride_error = r_out.stride_error;

endmodule

[hdl/strided_slice_address_generator_top.sv]
// Every accepted word gives its result word in the output register in the next cycle.
// A step word holds off further words while it passes through the shared 48x16 multiply-add
// once for each of axes 1 to 3 to build the next offset; a restart first computes the stop
// indices, then makes the same passes; a word arriving with no traversal running makes none.
// Reset (synchronous, active low) loads the default configuration and leaves no traversal.
`include "strided_slice_address_generator_top_macros.svh"

module strided_slice_address_generator_top import ssag_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssag_item_if.sink  i_item,
    ssag_cfg_if.sink   i_cfg,
    ssag_res_if.source o_res
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    ssag_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_restart  (i_item.restart),
        .o_in_ready (i_item.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ssag_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .i_cfg   (i_cfg),
        .o_res   (o_res)
    );

    `SSAG_ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n, i_item.valid && i_item.ready, o_res.valid)
    `SSAG_ASSERT_NOW(a_last_is_element, i_clk, i_rst_n, o_res.valid && o_res.last, o_res.valid_res)
    `SSAG_ASSERT_NOW(a_no_element_on_error, i_clk, i_rst_n, o_res.valid && o_res.valid_res, !o_res.stride_error)

endmodule

[dv/slice_offset_checker.sv]
`timescale 1ns / 1ps

module slice_offset_checker import ssag_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    ssag_item_if item_ch,
    ssag_cfg_if  cfg_ch,
    ssag_res_if  res_ch,
    output int   o_fail_count,
    output int   o_pending
);

    // Full-range values that the masks put in place of a begin or end index.
    localparam longint FULL_NEG = -64'sd2147483648;
    localparam longint FULL_POS = 64'sd2147483647;

    logic [CFG_W-1:0]  sizes_word, begins_word, ends_word, strides_word;
    logic [MASK_W-1:0] begin_full, end_full, single_mask;

    longint           ax_start [NUM_AXES];
    longint           ax_stop  [NUM_AXES];
    longint           ax_pos   [NUM_AXES];
    longint           ax_step  [NUM_AXES];
    logic [OFF_W-1:0] ax_pitch [NUM_AXES];
    logic [OFF_W-1:0] next_offset;
    bit               walking;
    bit               zero_stride;

    t_result expected_results[$];
    int      fail_tally = 0;

    assign o_fail_count = fail_tally;

    function automatic longint size_of(input int ax);
        return longint'(sizes_word[ax*SLOT_BITS +: AXIS_BITS]);
    endfunction

    function automatic longint signed_slot(input logic [CFG_W-1:0] word, input int ax);
        return longint'($signed(word[ax*SLOT_BITS +: AXIS_BITS]));
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (hi < v)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic bit at_stop(input longint idx, input longint stop, input longint stride);
        return (stride > 0) ? (idx >= stop) : (idx <= stop);
    endfunction

    function automatic logic [OFF_W-1:0] offset_now();
        logic [OFF_W-1:0] off;
        int ax;
        off = '0;
        for (ax = 0; ax < NUM_AXES; ax++)
            off += ax_pitch[ax] * OFF_W'(ax_pos[ax]);
        return off;
    endfunction

    task automatic clear_model();
        int ax;
        sizes_word   = RST_AXIS_SIZES;
        begins_word  = RST_BEGIN_INDICES;
        ends_word    = RST_END_INDICES;
        strides_word = RST_AXIS_STRIDES;
        begin_full   = RST_MASK;
        end_full     = RST_MASK;
        single_mask  = RST_MASK;
        for (ax = 0; ax < NUM_AXES; ax++) begin
            ax_start[ax] = 0;
            ax_stop[ax]  = 0;
            ax_pos[ax]   = 0;
            ax_step[ax]  = 0;
            ax_pitch[ax] = '0;
        end
        next_offset = '0;
        walking     = 1'b0;
        zero_stride = 1'b0;
        expected_results.delete();
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        case (idx)
            CFG_AXIS_SIZES:    sizes_word   = val;
            CFG_BEGIN_INDICES: begins_word  = val;
            CFG_END_INDICES:   ends_word    = val;
            CFG_AXIS_STRIDES:  strides_word = val;
            CFG_BEGIN_MASK:    begin_full   = val[MASK_W-1:0];
            CFG_END_MASK:      end_full     = val[MASK_W-1:0];
            CFG_SHRINK_MASK:   single_mask  = val[MASK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic plan_slice();
        longint sz, s, st, sp;
        bit empty;
        int ax;
        empty       = 1'b0;
        zero_stride = 1'b0;
        for (ax = 0; ax < NUM_AXES; ax++) begin
            sz = size_of(ax);
            s  = signed_slot(strides_word, ax);
            st = signed_slot(begins_word, ax);
            sp = signed_slot(ends_word, ax);
            if (s == 0)
                zero_stride = 1'b1;
            if (begin_full[ax])
                st = (s > 0) ? FULL_NEG : FULL_POS;
            if (st < 0)
                st += sz;
            st = clamp(st, 0, sz - 1);
            if (single_mask[ax])
                sp = st + 1;
            // A masked end wins over shrink.
            if (end_full[ax])
                sp = (s > 0) ? FULL_POS : FULL_NEG;
            if (sp < 0)
                sp += sz;
            sp = (s > 0) ? clamp(sp, 0, sz) : clamp(sp, -1, sz - 1);
            if (sz == 0 || at_stop(st, sp, s))
                empty = 1'b1;
            ax_start[ax] = st;
            ax_stop[ax]  = sp;
            ax_step[ax]  = s;
            ax_pos[ax]   = st;
        end
        ax_pitch[3] = 1;
        ax_pitch[2] = OFF_W'(size_of(3));
        ax_pitch[1] = ax_pitch[2] * OFF_W'(size_of(2));
        ax_pitch[0] = ax_pitch[1] * OFF_W'(size_of(1));
        walking     = !zero_stride && !empty;
        next_offset = walking ? offset_now() : '0;
    endtask

    task automatic predict_word(input logic restart);
        t_result r;
        longint n;
        bit fin;
        int ax;
        r   = '0;
        fin = 1'b0;
        if (restart) begin
            plan_slice();
        end else if (walking) begin
            r.read_offset = next_offset;
            r.valid_res   = 1'b1;
            fin           = 1'b1;
            // Innermost axis first; a finished axis rewinds and carries outward.
            for (ax = NUM_AXES - 1; ax >= 0 && fin; ax--) begin
                n = ax_pos[ax] + ax_step[ax];
                if (!at_stop(n, ax_stop[ax], ax_step[ax])) begin
                    ax_pos[ax] = n;
                    fin        = 1'b0;
                end else begin
                    ax_pos[ax] = ax_start[ax];
                end
            end
            if (fin)
                walking = 1'b0;
            else
                next_offset = offset_now();
        end
        r.last         = fin;
        r.stride_error = zero_stride;
        expected_results = {expected_results, r};
    endtask

    task automatic check_result();
        t_result want, got;
        got.read_offset  = res_ch.read_offset;
        got.valid_res    = res_ch.valid_res;
        got.last         = res_ch.last;
        got.stride_error = res_ch.stride_error;
        if (expected_results.size() == 0) begin
            fail_tally++;
            $display("%0t: result word with none expected: offset %h valid %b last %b err %b",
                     $time, got.read_offset, got.valid_res, got.last, got.stride_error);
        end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
                fail_tally++;
                $display("%0t: expected %h/%b/%b/%b, got %h/%b/%b/%b",
                         $time, want.read_offset, want.valid_res, want.last,
                         want.stride_error, got.read_offset, got.valid_res, got.last,
                         got.stride_error);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready)
                write_setting(cfg_ch.index, cfg_ch.data);
            if (res_ch.valid && res_ch.ready)
                check_result();
            if (item_ch.valid && item_ch.ready)
                predict_word(item_ch.restart);
        end
        o_pending = expected_results.size();
    end

endmodule

[dv/tb_strided_slice_address_generator_top.sv]
`timescale 1ns / 1ps

module tb_strided_slice_address_generator_top;
    import ssag_pkg::*;

    localparam int TOTAL_WORDS   = 650;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 150;
    // Index beyond the register list; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    typedef struct {
        logic [CFG_W-1:0]  sizes;
        logic [CFG_W-1:0]  begins;
        logic [CFG_W-1:0]  ends;
        logic [CFG_W-1:0]  strides;
        logic [MASK_W-1:0] begin_full;
        logic [MASK_W-1:0] end_full;
        logic [MASK_W-1:0] single;
    } t_slice_setup;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   words_sent;
    bit   tx_calm;
    bit   rx_calm;
    bit   hold_pending;

    ssag_item_if item_ch ();
    ssag_cfg_if  cfg_ch ();
    ssag_res_if  res_ch ();

    strided_slice_address_generator_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    slice_offset_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .item_ch      (item_ch),
        .cfg_ch       (cfg_ch),
        .res_ch       (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SLOT_BITS-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 85)
            return SLOT_BITS'($urandom_range(1, 4));
        if (r < 95)
            return SLOT_BITS'($urandom_range(5, 300));
        if (r < 98)
            return '1;
        return SLOT_BITS'($urandom);
    endfunction

    function automatic logic [SLOT_BITS-1:0] pick_stride();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return '0;
        if (r < 50)
            return SLOT_BITS'(1);
        if (r < 65)
            return SLOT_BITS'($urandom_range(2, 3));
        if (r < 85)
            return '1;
        if (r < 95)
            return SLOT_BITS'(-$urandom_range(2, 3));
        if (r < 97)
            return 16'h7fff;
        if (r < 99)
            return 16'h8000;
        return SLOT_BITS'($urandom);
    endfunction

    // Mostly indices near the axis range, so that wrapping and clamping both show up.
    function automatic logic [SLOT_BITS-1:0] pick_index(input int m);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            v = $urandom_range(0, 2 * m + 2);
            return SLOT_BITS'(v - (m + 1));
        end
        if (r < 85)
            return $urandom_range(0, 1) ? '1 : '0;
        return SLOT_BITS'($urandom);
    endfunction

    function automatic t_slice_setup roll_setup();
        t_slice_setup s;
        logic [SLOT_BITS-1:0] sz;
        int ax;
        int m;
        for (ax = 0; ax < NUM_AXES; ax++) begin
            sz = pick_size();
            m  = (sz > 6) ? 6 : int'(sz);
            s.sizes[ax*SLOT_BITS +: SLOT_BITS]   = sz;
            s.strides[ax*SLOT_BITS +: SLOT_BITS] = pick_stride();
            s.begins[ax*SLOT_BITS +: SLOT_BITS]  = pick_index(m);
            s.ends[ax*SLOT_BITS +: SLOT_BITS]    = pick_index(m);
        end
        s.begin_full = ($urandom_range(0, 2) == 0) ? '0 : MASK_W'($urandom);
        s.end_full   = ($urandom_range(0, 2) == 0) ? '0 : MASK_W'($urandom);
        s.single     = ($urandom_range(0, 2) == 0) ? '0 : MASK_W'($urandom);
        return s;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge i_clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge i_clk);
    endtask

    // Mask registers carry random upper bits, which the block must drop.
    task automatic load_setup(input t_slice_setup s);
        write_reg(CFG_AXIS_SIZES, s.sizes);
        write_reg(CFG_BEGIN_INDICES, s.begins);
        write_reg(CFG_END_INDICES, s.ends);
        write_reg(CFG_AXIS_STRIDES, s.strides);
        write_reg(CFG_BEGIN_MASK, {$urandom, 28'($urandom), s.begin_full});
        write_reg(CFG_END_MASK, {$urandom, 28'($urandom), s.end_full});
        write_reg(CFG_SHRINK_MASK, {$urandom, 28'($urandom), s.single});
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_SPARE, {$urandom, $urandom});
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic push_word(input logic restart);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.restart <= restart;
        do
            @(posedge i_clk);
        while (!(item_ch.valid && item_ch.ready));
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic run_slice(input int steps);
        push_word(1'b1);
        repeat (steps) push_word(1'b0);
    endtask

    // Stop offering words and wait until the block has answered all of them and gone quiet.
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin : sink_side
        int g;
        res_ch.ready = 1'b0;
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                g = LONG_HOLD;
            end else begin
                g = pick_gap(rx_calm);
            end
            if (g > 0) begin
                res_ch.ready <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int phase;
        int kind;
        item_ch.valid   = 1'b0;
        item_ch.restart = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;
        i_rst_n         = 1'b0;
        tx_calm         = 1'b0;
        rx_calm         = 1'b0;
        hold_pending    = 1'b0;
        words_sent      = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Steps with no traversal yet, then the single element of the reset setup.
        push_word(1'b0);
        push_word(1'b0);
        run_slice(2);

        // Full range in reverse on every axis.
        settle();
        load_setup('{64'h0003_0002_0002_0002, '0, '0, '1, 4'hf, 4'hf, 4'h0});
        run_slice(7);

        // A zero stride on one axis.
        settle();
        load_setup('{64'h0004_0004_0004_0004, '0, 64'h0004_0004_0004_0004,
                     64'h0001_0000_0001_0001, 4'h0, 4'h0, 4'h0});
        run_slice(2);

        // Shrink with a negative stride leaves nothing to emit.
        settle();
        load_setup('{64'h0003_0003_0003_0003, 64'h0001_0001_0001_0001, '0, '1,
                     4'h0, 4'h0, 4'hf});
        run_slice(1);

        // Shrink on the outer axes; the masked end overrides shrink on the inner one.
        settle();
        load_setup('{64'h0003_0003_0003_0003, 64'h0002_0001_0001_0001, '0,
                     64'hffff_0001_0001_0001, 4'h0, 4'h8, 4'hf});
        run_slice(4);

        // An axis of size zero.
        settle();
        load_setup('{64'h0002_0000_0002_0002, '0, '0, 64'h0001_0001_0001_0001,
                     4'hf, 4'hf, 4'h0});
        run_slice(1);

        // Largest sizes, last element of every axis.
        settle();
        load_setup('{'1, '1, '0, 64'h0001_0001_0001_0001, 4'h0, 4'h0, 4'hf});
        run_slice(1);

        phase = 0;
        while (words_sent < TOTAL_WORDS) begin
            settle();
            load_setup(roll_setup());
            tx_calm = ($urandom_range(0, 4) == 0);
            rx_calm = ($urandom_range(0, 4) == 0);
            if (phase == 0 || $urandom_range(0, 9) == 0)
                hold_pending = 1'b1;
            repeat ($urandom_range(1, 3)) begin
                kind = $urandom_range(0, 9);
                if (kind < 7)
                    run_slice($urandom_range(1, 30));
                else if (kind == 7)
                    run_slice($urandom_range(40, 80));
                else if (kind == 8)
                    repeat ($urandom_range(1, 6)) push_word(1'($urandom_range(0, 1)));
                else
                    repeat ($urandom_range(1, 4)) push_word(1'b0);
            end
            phase++;
        end

        settle();
        if (fail_count == 0)
            $display("tb_strided_slice_address_generator_top passed");
        else
            $display("tb_strided_slice_address_generator_top failed");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("tb_strided_slice_address_generator_top failed");
        $finish;
    end

endmodule
